// ----- src/mrct_pkg.sv -----
// shared types, widths and codes for the mouse report cursor tracker
package mrct_pkg;

	// cursor coordinate width
	localparam int COORD_BITS = 12;
	localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

	// configuration
	localparam int CFG_W      = 13;
	localparam int SCREEN_MAX = 4096;

	// field widths
	localparam int BYTE_W     = 8;
	localparam int REL_X_W    = 8;
	localparam int REL_Y_W    = 9;
	localparam int BTN_ID_W   = 2;
	localparam int KIND_W     = 2;

	// stream packing
	localparam int IN_DATA_W     = 3 * BYTE_W;
	localparam int OUT_DATA_BITS = 2 * COORD_BITS + REL_X_W + REL_Y_W + BTN_ID_W;
	localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W     = OUT_DATA_W - OUT_DATA_BITS;
	localparam int OFS_CURSOR_X  = 0;
	localparam int OFS_CURSOR_Y  = OFS_CURSOR_X + COORD_BITS;
	localparam int OFS_REL_X     = OFS_CURSOR_Y + COORD_BITS;
	localparam int OFS_REL_Y     = OFS_REL_X + REL_X_W;
	localparam int OFS_BTN_ID    = OFS_REL_Y + REL_Y_W;

	typedef enum logic [KIND_W-1:0] {
		EV_NONE   = 2'd0,
		EV_MOTION = 2'd1,
		EV_DOWN   = 2'd2,
		EV_UP     = 2'd3
	} event_kind_t;

	typedef enum logic [0:0] {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	// button identifiers and status bit masks
	localparam logic [BTN_ID_W-1:0] BTN_ID_NONE  = 2'd0;
	localparam logic [BTN_ID_W-1:0] BTN_ID_LEFT  = 2'd1;
	localparam logic [BTN_ID_W-1:0] BTN_ID_RIGHT = 2'd2;
	localparam logic [1:0]          BTN_LEFT     = 2'b01;
	localparam logic [1:0]          BTN_RIGHT    = 2'b10;

	typedef struct packed {
		logic [COORD_BITS-1:0] x_lim;
		logic [COORD_BITS-1:0] y_lim;
	} limits_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic [1:0]            buttons;
	} track_state_t;

	typedef struct packed {
		event_kind_t                 kind;
		logic [COORD_BITS-1:0]       cursor_x;
		logic [COORD_BITS-1:0]       cursor_y;
		logic signed [REL_X_W-1:0]   rel_x;
		logic signed [REL_Y_W-1:0]   rel_y;
		logic [BTN_ID_W-1:0]         button_id;
	} result_t;

endpackage

// ----- src/mouse_report_cursor_tracker.sv -----
// top level: report input stage, event core, tracking state and result register
// Takes one three-byte mouse report per transaction and returns exactly one event
// transaction for it. A report is held in the input register and its result is then
// registered in the result register; one report can be taken every cycle while the
// receiver keeps taking results. The only recurrence is the cursor and button state,
// which is updated in the same cycle the result register loads. The input side keeps
// accepting while a result waits, and stalls only when both the input and result
// registers are full. A zero delta pair with no left or right change gives an event
// of kind none. Screen width and height may be written at any idle moment; the cursor
// is clamped to a new size only by the next motion event.
module mouse_report_cursor_tracker (
	input  logic                             clk,
	input  logic                             arst_n,
	// report input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// status_byte, x_delta_byte, y_delta_byte (low to high)
	input  logic [mrct_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// event output stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// cursor_x, cursor_y, rel_x, rel_y, button_id, zero fill (low to high)
	output logic [mrct_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// event_kind
	output logic [mrct_pkg::KIND_W-1:0]      m_axis_tuser,
	// configuration write port
	input  logic                             cfg_we,
	input  mrct_pkg::cfg_reg_t               cfg_index,
	input  logic [mrct_pkg::CFG_W-1:0]       cfg_wdata
);
	import mrct_pkg::*;

	// input register
	logic                in_valid_s1;
	logic [BYTE_W-1:0]   status_s1;
	logic [BYTE_W-1:0]   x_delta_s1;
	logic [BYTE_W-1:0]   y_delta_s1;

	// result register
	logic                out_valid_s2;
	result_t             res_s2;

	// cursor and last button state
	track_state_t        track_q;
	track_state_t        track_nxt;
	result_t             res_nxt;
	limits_t             limits;
	logic                advance;

	mrct_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.limits    (limits)
	);

	mrct_event_core u_core (
		.status_byte  (status_s1),
		.x_delta_byte (x_delta_s1),
		.y_delta_byte (y_delta_s1),
		.cur          (track_q),
		.limits       (limits),
		.nxt          (track_nxt),
		.res          (res_nxt)
	);

	// report moves to the result register when that register is free or being emptied
	assign advance       = in_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			out_valid_s2 <= 1'b0;
			track_q      <= '0;
		end else begin
			if (s_axis_tready) begin
				in_valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_s2 <= 1'b1;
				track_q      <= track_nxt;
			end else if (m_axis_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			status_s1  <= s_axis_tdata[BYTE_W-1:0];
			x_delta_s1 <= s_axis_tdata[2*BYTE_W-1:BYTE_W];
			y_delta_s1 <= s_axis_tdata[3*BYTE_W-1:2*BYTE_W];
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_s2.button_id, res_s2.rel_y,
		res_s2.rel_x, res_s2.cursor_y, res_s2.cursor_x};

endmodule

// ----- src/mrct_cfg_regs.sv -----
// screen size registers and the cursor clamp limits derived from them
module mrct_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  mrct_pkg::cfg_reg_t          cfg_index,
	input  logic [mrct_pkg::CFG_W-1:0]  cfg_wdata,
	output mrct_pkg::limits_t           limits
);
	import mrct_pkg::*;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	// size to largest coordinate: zero acts as one, capped at screen max and coord range
	function automatic logic [COORD_BITS-1:0] limit_of(input logic [CFG_W-1:0] size);
		logic [CFG_W-1:0] s;
		if (size == '0) begin
			s = '0;
		end else if (size > CFG_W'(SCREEN_MAX)) begin
			s = CFG_W'(SCREEN_MAX - 1);
		end else begin
			s = size - 1'b1;
		end
		if (COORD_MAX < SCREEN_MAX - 1) begin
			if (s > CFG_W'(COORD_MAX)) begin
				s = CFG_W'(COORD_MAX);
			end
		end
		return COORD_BITS'(s);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1024);
			height_q <= CFG_W'(768);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_wdata;
				REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign limits.x_lim = limit_of(width_q);
	assign limits.y_lim = limit_of(height_q);

endmodule

// ----- src/mrct_event_core.sv -----
// report decode, cursor move and clamp, and event selection
module mrct_event_core (
	input  logic [mrct_pkg::BYTE_W-1:0] status_byte,
	input  logic [mrct_pkg::BYTE_W-1:0] x_delta_byte,
	input  logic [mrct_pkg::BYTE_W-1:0] y_delta_byte,
	input  mrct_pkg::track_state_t      cur,
	input  mrct_pkg::limits_t           limits,
	output mrct_pkg::track_state_t      nxt,
	output mrct_pkg::result_t           res
);
	import mrct_pkg::*;

	localparam int SUM_W = COORD_BITS + 2;

	logic signed [REL_X_W-1:0] dx;
	logic signed [REL_Y_W-1:0] dy;
	logic [1:0]                buttons;
	logic [1:0]                changed;
	logic                      motion;
	logic [COORD_BITS-1:0]     new_col;
	logic [COORD_BITS-1:0]     new_row;

	function automatic logic [COORD_BITS-1:0] move_clamp(
		input logic [COORD_BITS-1:0]     pos,
		input logic signed [REL_Y_W-1:0] delta,
		input logic [COORD_BITS-1:0]     lim
	);
		logic signed [SUM_W-1:0] sum;
		sum = $signed({2'b00, pos}) + $signed({{(SUM_W-REL_Y_W){delta[REL_Y_W-1]}}, delta});
		if (sum[SUM_W-1]) begin
			return '0;
		end else if (sum > $signed({2'b00, lim})) begin
			return lim;
		end else begin
			return sum[COORD_BITS-1:0];
		end
	endfunction

	always_comb begin
		dx      = $signed(x_delta_byte);
		dy      = REL_Y_W'(0) - $signed({y_delta_byte[BYTE_W-1], y_delta_byte});
		buttons = status_byte[1:0];
		changed = buttons ^ cur.buttons;
		motion  = (x_delta_byte != '0) || (y_delta_byte != '0);
		new_col = move_clamp(cur.col, {dx[REL_X_W-1], dx}, limits.x_lim);
		new_row = move_clamp(cur.row, dy, limits.y_lim);

		nxt           = cur;
		res.kind      = EV_NONE;
		res.rel_x     = '0;
		res.rel_y     = '0;
		res.button_id = BTN_ID_NONE;

		if (motion) begin
			nxt.col   = new_col;
			nxt.row   = new_row;
			res.kind  = EV_MOTION;
			res.rel_x = dx;
			res.rel_y = dy;
		end else if ((changed & BTN_LEFT) != '0) begin
			nxt.buttons   = buttons;
			res.button_id = BTN_ID_LEFT;
			res.kind      = ((buttons & BTN_LEFT) != '0) ? EV_DOWN : EV_UP;
		end else if ((changed & BTN_RIGHT) != '0) begin
			nxt.buttons   = buttons;
			res.button_id = BTN_ID_RIGHT;
			res.kind      = ((buttons & BTN_RIGHT) != '0) ? EV_DOWN : EV_UP;
		end

		res.cursor_x = nxt.col;
		res.cursor_y = nxt.row;
	end

endmodule

// ----- src/mrct_checker.sv -----
// port-level checks for the mouse report cursor tracker, bound to the top level
module mrct_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [mrct_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic [mrct_pkg::KIND_W-1:0]      m_axis_tuser
);
	import mrct_pkg::*;

	logic [REL_X_W-1:0]  rel_x;
	logic [REL_Y_W-1:0]  rel_y;
	logic [BTN_ID_W-1:0] button_id;

	assign rel_x     = m_axis_tdata[OFS_REL_X +: REL_X_W];
	assign rel_y     = m_axis_tdata[OFS_REL_Y +: REL_Y_W];
	assign button_id = m_axis_tdata[OFS_BTN_ID +: BTN_ID_W];

	// a held result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// input only backs up behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled with no result waiting");

	// a motion event carries a nonzero delta and no button
	a_motion_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_MOTION |->
		(rel_x != '0 || rel_y != '0) && button_id == BTN_ID_NONE)
		else $error("motion event with bad fields");

	// button events name a button and carry no delta
	a_button_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == EV_DOWN || m_axis_tuser == EV_UP) |->
		(button_id == BTN_ID_LEFT || button_id == BTN_ID_RIGHT) &&
		rel_x == '0 && rel_y == '0)
		else $error("button event with bad fields");

	// an empty event carries nothing but the cursor
	a_none_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_NONE |->
		rel_x == '0 && rel_y == '0 && button_id == BTN_ID_NONE)
		else $error("empty event with nonzero fields");

endmodule

bind mouse_report_cursor_tracker mrct_checker u_mrct_checker (.*);

// ----- test/mouse_report_cursor_tracker_tb.sv -----
// testbench for the mouse report cursor tracker: predicted events checked per transaction
module mouse_report_cursor_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mrct_pkg::*;

	// generous cycle budget, far above the slowest legal run
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned PHASE_ITEMS   = 160;
	localparam int unsigned PHASES        = 7;
	localparam int unsigned LONG_HOLD     = 250;
	localparam int unsigned SETTLE_CYCLES = 4;

	// tracks the cursor and buttons the way the block should, and holds the events
	// still owed by the block in arrival order
	class event_ledger;
		result_t               awaited[$];
		logic [CFG_W-1:0]      width_reg;
		logic [CFG_W-1:0]      height_reg;
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic [1:0]            buttons;
		int unsigned           errors;

		function new();
			width_reg  = 13'd1024;
			height_reg = 13'd768;
			col        = '0;
			row        = '0;
			buttons    = 2'b00;
			errors     = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
			if (idx == REG_SCREEN_WIDTH)
				width_reg = value;
			else
				height_reg = value;
		endfunction

		// largest coordinate allowed for a screen size register value
		function int edge_of(logic [CFG_W-1:0] size);
			int s;
			s = int'(size);
			if (s < 1)
				s = 1;
			if (s > SCREEN_MAX)
				s = SCREEN_MAX;
			s = s - 1;
			if (s > COORD_MAX)
				s = COORD_MAX;
			return s;
		endfunction

		function logic [COORD_BITS-1:0] moved(logic [COORD_BITS-1:0] pos, int delta, int lim);
			int p;
			p = int'(pos) + delta;
			if (p < 0)
				p = 0;
			if (p > lim)
				p = lim;
			return p[COORD_BITS-1:0];
		endfunction

		// one accepted report: work out its event and queue it
		function void note_report(logic [IN_DATA_W-1:0] report);
			logic [1:0] pressed;
			int         dx;
			int         dy;
			result_t    r;
			pressed     = report[1:0];
			dx          = int'($signed(report[15:8]));
			dy          = -int'($signed(report[23:16]));
			r.kind      = EV_NONE;
			r.rel_x     = '0;
			r.rel_y     = '0;
			r.button_id = BTN_ID_NONE;
			if (dx != 0 || dy != 0) begin
				r.kind  = EV_MOTION;
				col     = moved(col, dx, edge_of(width_reg));
				row     = moved(row, dy, edge_of(height_reg));
				r.rel_x = dx[REL_X_W-1:0];
				r.rel_y = dy[REL_Y_W-1:0];
			end else if (((pressed ^ buttons) & BTN_LEFT) != 2'b00) begin
				r.button_id = BTN_ID_LEFT;
				r.kind      = ((pressed & BTN_LEFT) != 2'b00) ? EV_DOWN : EV_UP;
				buttons     = pressed;
			end else if (((pressed ^ buttons) & BTN_RIGHT) != 2'b00) begin
				r.button_id = BTN_ID_RIGHT;
				r.kind      = ((pressed & BTN_RIGHT) != 2'b00) ? EV_DOWN : EV_UP;
				buttons     = pressed;
			end
			r.cursor_x = col;
			r.cursor_y = row;
			awaited.push_back(r);
		endfunction

		function void match(string field, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_event(logic [KIND_W-1:0] kind, logic [OUT_DATA_W-1:0] data);
			result_t want;
			if (awaited.size() == 0) begin
				$error("event transaction with no report pending");
				errors++;
				return;
			end
			want = awaited.pop_front();
			match("event_kind", int'(want.kind), int'(kind));
			match("cursor_x", int'(want.cursor_x), int'(data[OFS_CURSOR_X +: COORD_BITS]));
			match("cursor_y", int'(want.cursor_y), int'(data[OFS_CURSOR_Y +: COORD_BITS]));
			match("rel_x", int'(want.rel_x), int'($signed(data[OFS_REL_X +: REL_X_W])));
			match("rel_y", int'(want.rel_y), int'($signed(data[OFS_REL_Y +: REL_Y_W])));
			match("button_id", int'(want.button_id), int'(data[OFS_BTN_ID +: BTN_ID_W]));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [KIND_W-1:0]     m_axis_tuser;
	logic                  cfg_we = 1'b0;
	cfg_reg_t              cfg_index = REG_SCREEN_WIDTH;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	event_ledger book = new();

	// quiet turns off all idling on both sides for the closing stretch
	bit          quiet = 1'b0;
	// one-shot request for the long receiver hold-off
	bit          rx_long_hold = 1'b0;
	int unsigned rx_stall_left = 0;
	int unsigned cycle_count = 0;

	mouse_report_cursor_tracker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("mouse_report_cursor_tracker test failed");
			$finish;
		end
	end

	// event receiver: short random stall bursts, plus one long hold-off on request,
	// counted here so the sender keeps offering reports while the block backs up
	always @(negedge clk) begin
		if (rx_long_hold) begin
			rx_stall_left = LONG_HOLD;
			rx_long_hold  = 1'b0;
		end
		if (rx_stall_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 5) == 0)
				rx_stall_left = $urandom_range(1, 6);
		end
	end

	// every completed event transaction goes to the ledger
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			book.check_event(m_axis_tuser, m_axis_tdata);
	end

	function automatic logic [IN_DATA_W-1:0] report_of(logic [7:0] status, logic [7:0] xd,
			logic [7:0] yd);
		return {yd, xd, status};
	endfunction

	// mostly motion and button traffic, some small nudges and single-axis moves
	function automatic logic [IN_DATA_W-1:0] random_report();
		logic [7:0]  status;
		logic [7:0]  xd;
		logic [7:0]  yd;
		int unsigned pick;
		status = 8'($urandom);
		pick   = $urandom_range(0, 99);
		if (pick < 40) begin
			xd = 8'($urandom);
			yd = 8'($urandom);
		end else if (pick < 55) begin
			xd = 8'($urandom_range(0, 4)) - 8'd2;
			yd = 8'($urandom_range(0, 4)) - 8'd2;
		end else if (pick < 92) begin
			xd = 8'd0;
			yd = 8'd0;
		end else if (pick < 96) begin
			xd = 8'($urandom);
			yd = 8'd0;
		end else begin
			xd = 8'd0;
			yd = 8'($urandom);
		end
		return report_of(status, xd, yd);
	endfunction

	// hold the report on the bus until the block takes it
	task automatic send_report(input logic [IN_DATA_W-1:0] report);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= report;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		book.note_report(report);
	endtask

	// send, then maybe leave the input idle for a short burst
	task automatic offer(input logic [IN_DATA_W-1:0] report);
		int unsigned gap;
		send_report(report);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// stop sending and wait until every owed event has come back
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (book.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		book.set_reg(idx, value);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		// screen sizes per random phase: shrink under the cursor first, then zero and over-range,
		// the largest screen, over-range and zero, one pixel, random, defaults
		logic [CFG_W-1:0] phase_w[PHASES];
		logic [CFG_W-1:0] phase_h[PHASES];
		phase_w = '{13'd5, 13'd0, 13'd4096, 13'd8191, 13'd1, 13'd0, 13'd1024};
		phase_h = '{13'd3, 13'd8191, 13'd4096, 13'd0, 13'd1, 13'd0, 13'd768};
		phase_w[5] = 13'($urandom_range(0, 8191));
		phase_h[5] = 13'($urandom_range(0, 8191));

		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;

		// directed part, reset screen of 1024 by 768
		offer(report_of(8'h00, 8'h00, 8'h00));   // nothing at all
		offer(report_of(8'h01, 8'h00, 8'h00));   // left down
		offer(report_of(8'h01, 8'h00, 8'h00));   // left held, event of kind none
		offer(report_of(8'h03, 8'h00, 8'h00));   // right down
		offer(report_of(8'h00, 8'h00, 8'h00));   // both released: left up only
		offer(report_of(8'h00, 8'h00, 8'h00));   // right already absorbed
		offer(report_of(8'h02, 8'h01, 8'h00));   // motion hides the right press
		offer(report_of(8'h02, 8'h00, 8'h00));   // right press shows up now
		offer(report_of(8'hFE, 8'h00, 8'h00));   // middle, sign and overflow bits ignored
		offer(report_of(8'hFC, 8'h00, 8'h00));   // right up
		offer(report_of(8'h00, 8'h80, 8'h80));   // most negative bytes, left edge clamp
		offer(report_of(8'h00, 8'h7F, 8'h7F));   // most positive bytes, cursor moves up
		offer(report_of(8'h00, 8'h80, 8'h01));
		offer(report_of(8'h00, 8'hFF, 8'hFF));
		offer(report_of(8'h00, 8'h00, 8'h01));   // y only
		repeat (9)
			offer(report_of(8'hFF, 8'h7F, 8'h80)); // run into the far corner
		offer(report_of(8'hFF, 8'h00, 8'h00));   // both pressed: left down only
		drain();

		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			write_reg(REG_SCREEN_WIDTH, phase_w[ph]);
			write_reg(REG_SCREEN_HEIGHT, phase_h[ph]);
			if (ph == PHASES - 1)
				quiet = 1'b1;
			for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off early in the largest-screen phase
				if (ph == 2 && n == 10)
					rx_long_hold = 1'b1;
				offer(random_report());
			end
			drain();
		end

		if (book.errors == 0 && book.awaited.size() == 0)
			$display("mouse_report_cursor_tracker test passed");
		else
			$display("mouse_report_cursor_tracker test failed");
		$finish;
	end

endmodule

// ----- mouse_report_cursor_tracker.f -----
src/mrct_pkg.sv
src/mrct_cfg_regs.sv
src/mrct_event_core.sv
src/mouse_report_cursor_tracker.sv
src/mrct_checker.sv
test/mouse_report_cursor_tracker_tb.sv
